>>> sv/fcdt_pkg.sv
// Shared types and constants for the fragment coverage and depth test block.
package fcdt_pkg;

	localparam int unsigned EW = 36;
	localparam int unsigned DW = 33;
	localparam int unsigned NW = 51;
	localparam int unsigned QW = 17;
	localparam logic [15:0] DEPTH_MAX = 16'hFFFF;
	localparam logic [15:0] W_ONE = 16'h8000;
	localparam logic FUNC_TEST = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic start_edge;
		logic start_div;
		logic [1:0] div_sel;
		logic load_w;
		logic start_mac;
		logic mac_step;
		logic mem_rd;
		logic mem_wr_test;
		logic mem_wr_clear;
		logic out_load;
		logic clr_step;
	} fcdt_cmd_t;

	typedef struct packed {
		logic covered;
		logic clearing;
		logic on_screen;
		logic div_done;
		logic clr_done;
	} fcdt_sts_t;

endpackage

>>> sv/fcdt_div.sv
// Restoring divider producing a 17-bit quotient, one bit per cycle.
module fcdt_div import fcdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [EW-1:0] num,
	input  logic [DW-1:0] den,
	output logic done,
	output logic [QW-1:0] quo
);
	logic [NW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [DW:0] trial;
	logic [NW-1:0] sh;

	assign sh = {rem_q[NW-2:0], 1'b0};
	assign trial = sh[NW-1:QW] - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// The numerator enters scaled by 2^15 so the quotient comes out in Q2.15.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {num, {(NW-EW){1'b0}}};
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DW])
				rem_q <= {1'b0, trial[DW-1:0], sh[QW-1:1], 1'b1};
			else
				rem_q <= {sh[NW-1:1], 1'b0};
		end
	end

	assign quo = rem_q[QW-1:0];
endmodule

>>> sv/fcdt_dp.sv
// Datapath: edge functions, weights, depth interpolation and depth store.
module fcdt_dp import fcdt_pkg::*; #(
	parameter int unsigned SCREEN_W = 1024,
	parameter int unsigned SCREEN_H = 1024,
	parameter int unsigned AW = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  fcdt_cmd_t cmd,
	output fcdt_sts_t sts,
	input  logic [167:0] in_data,
	input  logic in_func,
	output logic [65:0] res_q
);
	logic [9:0] x_in, y_in;
	logic signed [15:0] ax, ay, bx, by, cx, cy;
	logic [15:0] az, bz, cz;
	assign x_in = in_data[9:0];
	assign y_in = in_data[19:10];
	assign ax = in_data[35:20];
	assign ay = in_data[51:36];
	assign az = in_data[67:52];
	assign bx = in_data[83:68];
	assign by = in_data[99:84];
	assign bz = in_data[115:100];
	assign cx = in_data[131:116];
	assign cy = in_data[147:132];
	assign cz = in_data[163:148];

	function automatic logic signed [EW-1:0] efn(
		input logic signed [15:0] px, input logic signed [15:0] py,
		input logic signed [15:0] qx, input logic signed [15:0] qy,
		input logic signed [16:0] x, input logic signed [16:0] y);
		logic signed [16:0] dy, dx;
		logic signed [33:0] t0, t1;
		logic signed [31:0] t2, t3;
		logic signed [EW-1:0] r;
		dy = {py[15], py} - {qy[15], qy};
		dx = {qx[15], qx} - {px[15], px};
		t0 = dy * x;
		t1 = dx * y;
		t2 = px * qy;
		t3 = qx * py;
		r = EW'(t0) + EW'(t1) + EW'(t2) - EW'(t3);
		return r;
	endfunction

	function automatic logic [EW-1:0] mg(input logic signed [EW-1:0] v);
		return v[EW-1] ? EW'(-v) : EW'(v);
	endfunction

	logic signed [16:0] px, py;
	assign px = {3'b000, x_in, 4'b1000};
	assign py = {3'b000, y_in, 4'b1000};

	logic signed [EW-1:0] area_q, ea_q, eb_q, ec_q;
	logic [15:0] az_q, bz_q, cz_q;
	logic [AW-1:0] idx_q;
	logic func_q, onscr_q;
	logic [15:0] wa_q, wb_q, wc_q;
	logic [33:0] acc_q;
	logic [1:0] mstep_q;
	logic [15:0] rd_q;
	logic [AW:0] clr_q;

	logic onscr;
	assign onscr = (32'(x_in) < SCREEN_W) && (32'(y_in) < SCREEN_H);

	always_ff @(posedge clk) begin
		if (cmd.start_edge) begin
			area_q <= efn(bx, by, cx, cy, {ax[15], ax}, {ay[15], ay});
			ea_q <= efn(bx, by, cx, cy, px, py);
			eb_q <= efn(cx, cy, ax, ay, px, py);
			ec_q <= efn(ax, ay, bx, by, px, py);
			az_q <= az;
			bz_q <= bz;
			cz_q <= cz;
			func_q <= in_func;
			onscr_q <= onscr;
			idx_q <= AW'((32'(SCREEN_H) - 32'd1 - 32'(y_in)) * 32'(SCREEN_W) + 32'(x_in));
		end
	end

	logic ins;
	always_comb begin
		if (!area_q[EW-1] && area_q != '0)
			ins = !ea_q[EW-1] && ea_q != '0 && !eb_q[EW-1] && eb_q != '0
				&& !ec_q[EW-1] && ec_q != '0;
		else if (area_q[EW-1])
			ins = ea_q[EW-1] && eb_q[EW-1] && ec_q[EW-1];
		else
			ins = 1'b0;
	end

	logic [EW-1:0] num;
	always_comb begin
		case (cmd.div_sel)
			2'd0: num = mg(ea_q);
			2'd1: num = mg(eb_q);
			default: num = mg(ec_q);
		endcase
	end

	logic [EW-1:0] area_mag;
	logic div_done;
	logic [QW-1:0] quo;
	logic [15:0] wsat;
	assign area_mag = mg(area_q);
	fcdt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_div), .num(num),
		.den(area_mag[DW-1:0]), .done(div_done), .quo(quo)
	);
	assign wsat = (quo > QW'(W_ONE)) ? W_ONE : quo[15:0];

	always_ff @(posedge clk) begin
		if (cmd.load_w) begin
			case (cmd.div_sel)
				2'd0: wa_q <= wsat;
				2'd1: wb_q <= wsat;
				default: wc_q <= wsat;
			endcase
		end
	end

	logic [31:0] prod;
	always_comb begin
		case (mstep_q)
			2'd0: prod = wa_q * az_q;
			2'd1: prod = wb_q * bz_q;
			default: prod = wc_q * cz_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start_mac) begin
			acc_q <= '0;
			mstep_q <= '0;
		end else if (cmd.mac_step) begin
			acc_q <= acc_q + 34'(prod);
			mstep_q <= mstep_q + 2'd1;
		end
	end

	logic [18:0] zfull;
	logic [15:0] z;
	assign zfull = acc_q[33:15];
	assign z = (zfull > 19'(DEPTH_MAX)) ? DEPTH_MAX : zfull[15:0];

	logic [15:0] mem [2**AW];
	logic [AW-1:0] waddr;
	logic [15:0] wdata;
	logic we, pass;
	assign pass = onscr_q && (z < rd_q);
	assign we = cmd.clr_step || cmd.mem_wr_clear || (cmd.mem_wr_test && pass);
	assign waddr = cmd.clr_step ? clr_q[AW-1:0] : idx_q;
	assign wdata = (cmd.mem_wr_test && !cmd.clr_step) ? z : DEPTH_MAX;

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) rd_q <= mem[idx_q];
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
	end

	assign sts.clr_done = (clr_q == (AW+1)'(SCREEN_W * SCREEN_H - 1));
	assign sts.covered = ins;
	assign sts.clearing = func_q;
	assign sts.on_screen = onscr_q;
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (func_q || !ins) res_q <= '0;
			else res_q <= {z, wc_q, wb_q, wa_q, pass, 1'b1};
		end
	end
endmodule

>>> sv/fcdt_ctrl.sv
// Controller state machine sequencing the datapath for one transaction.
module fcdt_ctrl import fcdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  fcdt_sts_t sts,
	output fcdt_cmd_t cmd,
	output logic in_ready,
	output logic res_valid
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_EVAL, S_DIV, S_WAIT, S_MAC, S_RD, S_WR, S_OUT
	} state_t;
	state_t state_q;
	logic [1:0] sel_q, mac_q;

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.clr_step = (state_q == S_CLR);
		cmd.start_edge = in_fire;
		cmd.start_div = (state_q == S_DIV);
		cmd.load_w = (state_q == S_WAIT) && sts.div_done;
		cmd.start_mac = (state_q == S_EVAL);
		cmd.mac_step = (state_q == S_MAC);
		cmd.mem_rd = (state_q == S_RD);
		cmd.mem_wr_test = (state_q == S_WR) && !sts.clearing && sts.covered;
		cmd.mem_wr_clear = (state_q == S_EVAL) && sts.clearing && sts.on_screen;
		cmd.out_load = (state_q == S_OUT) && out_free;
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sel_q <= '0;
			mac_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) res_valid <= 1'b1;
			else if (out_free) res_valid <= 1'b0;
			case (state_q)
				S_CLR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_fire) state_q <= S_EVAL;
				S_EVAL: begin
					sel_q <= '0;
					mac_q <= '0;
					state_q <= (sts.clearing || !sts.covered) ? S_OUT : S_DIV;
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: if (sts.div_done) begin
					if (sel_q == 2'd2) state_q <= S_MAC;
					else begin
						sel_q <= sel_q + 2'd1;
						state_q <= S_DIV;
					end
				end
				S_MAC: begin
					mac_q <= mac_q + 2'd1;
					if (mac_q == 2'd2) state_q <= S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> state_q == S_EVAL)
		else $error("accepted transaction did not start evaluation");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load_w |-> state_q == S_WAIT)
		else $error("weight loaded outside division wait");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("input ready during clearing pass");
endmodule

>>> sv/fragment_coverage_depth_test.sv
// Top level of the fragment coverage and depth test block.
// Usage: one transaction on the s_axis channel carries a pixel and its
// triangle; one result transaction leaves on m_axis for each one accepted.
// tuser selects the operation: 0 tests the fragment, 1 clears its depth entry.
// A covered pixel passes through edge evaluation, then the shared divider
// once for each of the three weights, then three multiply-accumulate
// steps and the depth store read and write before its result is ready.
// Uncovered pixels and clears go from edge evaluation straight to the
// output stage.
// Only one transaction is in flight; s_axis_tready is high while idle.
// The result sits in an output register, so the next input is taken while
// the previous result still waits for m_axis_tready.
// After reset the depth store is swept to maximum depth, one entry per
// cycle, over all SCREEN_W*SCREEN_H entries, during which no input is accepted.
// A stalled receiver holds the result; the block waits before publishing
// the following one.
module fragment_coverage_depth_test import fcdt_pkg::*; #(
	parameter int unsigned SCREEN_W = 1024,
	parameter int unsigned SCREEN_H = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pix_x, pix_y, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
	input  logic [167:0] s_axis_tdata,
	// func
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// covered, depth_pass, weight_a, weight_b, weight_c, frag_depth, zero pad
	output logic [71:0] m_axis_tdata
);
	localparam int unsigned AW = $clog2(SCREEN_W * SCREEN_H);
	fcdt_cmd_t cmd;
	fcdt_sts_t sts;
	logic in_fire, out_free;
	logic [65:0] res;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	fcdt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .res_valid(m_axis_tvalid)
	);

	fcdt_dp #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .AW(AW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data(s_axis_tdata), .in_func(s_axis_tuser), .res_q(res)
	);

	assign m_axis_tdata = {6'b0, res};
endmodule

>>> tb/sv/fragment_coverage_depth_test_tb.sv
`timescale 1ns / 1ps
// Self-checking bench: fragment coverage, barycentric weights and depth store updates.
module fragment_coverage_depth_test_tb import fcdt_pkg::*; ();

	localparam int unsigned WIDTH_PX = 1024;
	localparam int unsigned HEIGHT_PX = 1024;
	localparam int unsigned RANDOM_FRAGS = 1036;
	localparam int unsigned STALL_LIMIT = 4_500_000;

	typedef struct {
		logic func;
		logic [9:0] px;
		logic [9:0] py;
		logic signed [15:0] ax, ay;
		logic [15:0] az;
		logic signed [15:0] bx, by;
		logic [15:0] bz;
		logic signed [15:0] cx, cy;
		logic [15:0] cz;
	} frag_t;

	typedef struct {
		logic covered;
		logic depth_pass;
		logic [15:0] wa, wb, wc;
		logic [15:0] depth;
	} shade_t;

	typedef struct {
		frag_t frag;
		bit typed;
		shade_t want;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	logic [15:0] zbuf_model [int unsigned];
	shade_t pending_shades[$];
	int unsigned errors = 0;
	int unsigned src_idle_pct = 7;
	int unsigned snk_stall_pct = 86;
	int unsigned quiet_cycles = 0;
	int unsigned seen_covered = 0;
	int unsigned seen_pass = 0;
	vector_t vectors[$];

	fragment_coverage_depth_test #(.SCREEN_W(WIDTH_PX), .SCREEN_H(HEIGHT_PX)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint edge_val(longint px, longint py, longint qx, longint qy,
			longint x, longint y);
		return (py - qy) * x + (qx - px) * y + px * qy - qx * py;
	endfunction

	function automatic longint magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [15:0] stored_depth(int unsigned idx);
		return zbuf_model.exists(idx) ? zbuf_model[idx] : DEPTH_MAX;
	endfunction

	// Computes the result of one fragment and applies its effect on the depth store.
	function automatic shade_t shade_fragment(frag_t f);
		shade_t r = '{default: '0};
		int unsigned idx;
		longint cxq, cyq, area, ea, eb, ec, d, wa, wb, wc, z;
		bit ins;
		idx = (HEIGHT_PX - 1 - f.py) * WIDTH_PX + f.px;
		if (f.func == FUNC_CLEAR) begin
			zbuf_model[idx] = DEPTH_MAX;
			return r;
		end
		cxq = longint'(f.px) * 16 + 8;
		cyq = longint'(f.py) * 16 + 8;
		area = edge_val(f.bx, f.by, f.cx, f.cy, f.ax, f.ay);
		ea = edge_val(f.bx, f.by, f.cx, f.cy, cxq, cyq);
		eb = edge_val(f.cx, f.cy, f.ax, f.ay, cxq, cyq);
		ec = edge_val(f.ax, f.ay, f.bx, f.by, cxq, cyq);
		if (area > 0)
			ins = ea > 0 && eb > 0 && ec > 0;
		else if (area < 0)
			ins = ea < 0 && eb < 0 && ec < 0;
		else
			ins = 0;
		if (!ins)
			return r;
		d = magn(area);
		wa = (magn(ea) << 15) / d;
		wb = (magn(eb) << 15) / d;
		wc = (magn(ec) << 15) / d;
		if (wa > 32768) wa = 32768;
		if (wb > 32768) wb = 32768;
		if (wc > 32768) wc = 32768;
		z = (wa * longint'(f.az) + wb * longint'(f.bz) + wc * longint'(f.cz)) >>> 15;
		if (z > 65535) z = 65535;
		r.covered = 1'b1;
		r.wa = wa[15:0];
		r.wb = wb[15:0];
		r.wc = wc[15:0];
		r.depth = z[15:0];
		if (z[15:0] < stored_depth(idx)) begin
			zbuf_model[idx] = z[15:0];
			r.depth_pass = 1'b1;
		end
		return r;
	endfunction

	function automatic frag_t tri_frag(logic func, int x, int y, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz);
		frag_t f;
		f.func = func; f.px = 10'(x); f.py = 10'(y);
		f.ax = 16'(ax); f.ay = 16'(ay); f.az = 16'(az);
		f.bx = 16'(bx); f.by = 16'(by); f.bz = 16'(bz);
		f.cx = 16'(cx); f.cy = 16'(cy); f.cz = 16'(cz);
		return f;
	endfunction

	function automatic frag_t random_frag();
		frag_t f;
		int unsigned pick;
		int sx, sy, span;
		pick = $urandom_range(99);
		if (pick < 15) begin
			f.func = 1'($urandom_range(1));
			f.px = 10'($urandom); f.py = 10'($urandom);
			f.ax = 16'($urandom); f.ay = 16'($urandom); f.az = 16'($urandom);
			f.bx = 16'($urandom); f.by = 16'($urandom); f.bz = 16'($urandom);
			f.cx = 16'($urandom); f.cy = 16'($urandom); f.cz = 16'($urandom);
			return f;
		end
		// Pixels mostly come from a small patch so that depth entries get reused.
		f.func = (pick < 25) ? FUNC_CLEAR : FUNC_TEST;
		f.px = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(3));
		f.py = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(3));
		sx = int'(f.px) * 16 + 8;
		sy = int'(f.py) * 16 + 8;
		span = 16 << $urandom_range(8);
		f.ax = 16'(sx + $urandom_range(2 * span) - span);
		f.ay = 16'(sy + $urandom_range(2 * span) - span);
		f.bx = 16'(sx + $urandom_range(2 * span) - span);
		f.by = 16'(sy + $urandom_range(2 * span) - span);
		f.cx = 16'(sx + $urandom_range(2 * span) - span);
		f.cy = 16'(sy + $urandom_range(2 * span) - span);
		f.az = 16'($urandom); f.bz = 16'($urandom); f.cz = 16'($urandom);
		return f;
	endfunction

	task automatic issue_fragment(frag_t f, bit typed, shade_t want);
		shade_t guess;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f.func;
		s_axis_tdata <= {4'd0, f.cz, f.cy, f.cx, f.bz, f.by, f.bx, f.az, f.ay, f.ax,
			f.py, f.px};
		do @(posedge clk); while (!s_axis_tready);
		guess = shade_fragment(f);
		pending_shades.push_back(typed ? want : guess);
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		shade_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.covered = m_axis_tdata[0];
			got.depth_pass = m_axis_tdata[1];
			got.wa = m_axis_tdata[17:2];
			got.wb = m_axis_tdata[33:18];
			got.wc = m_axis_tdata[49:34];
			got.depth = m_axis_tdata[65:50];
			if (pending_shades.size() == 0) begin
				$error("result transaction with no fragment outstanding");
				errors++;
			end else begin
				want = pending_shades.pop_front();
				compare_field("covered", 16'(want.covered), 16'(got.covered));
				compare_field("depth_pass", 16'(want.depth_pass), 16'(got.depth_pass));
				compare_field("weight_a", want.wa, got.wa);
				compare_field("weight_b", want.wb, got.wb);
				compare_field("weight_c", want.wc, got.wc);
				compare_field("frag_depth", want.depth, got.depth);
				seen_covered += got.covered;
				seen_pass += got.depth_pass;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_shades.size());
			$display("FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		shade_t blank = '{default: '0};
		int unsigned drain;
		vectors = '{
			'{tri_frag(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, blank},
			'{tri_frag(FUNC_CLEAR, 1023, 1023, -1, -1, 65535, -1, -1, 65535, -1, -1, 65535),
				1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 8, 8, 100, 8, 8, 100, 8, 8, 100), 1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 0, 100, 64, 64, 200, 128, 128, 300), 1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 8, 8, 100, 100, 8, 200, 8, 100, 300), 1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 8, 100, 100, 8, 200, 0, 100, 300), 1, blank},
			'{tri_frag(FUNC_TEST, 1023, 1023, 0, 0, 1, 64, 0, 2, 0, 64, 3), 1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 0, 4096, 64, 0, 8192, 0, 64, 12288), 0, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 0, 9000, 0, 64, 9000, 64, 0, 9000), 0, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 0, 100, 0, 64, 100, 64, 0, 100), 0, blank},
			'{tri_frag(FUNC_TEST, 5, 5, 0, 0, 65535, 200, 0, 65535, 0, 200, 65535), 0, blank},
			'{tri_frag(FUNC_TEST, 1023, 1023, -32768, -32768, 0, 32767, -32768, 65535,
				-32768, 32767, 0), 0, blank},
			'{tri_frag(FUNC_TEST, 0, 0, -32768, -32768, 65535, -32768, 32767, 65535,
				32767, -32768, 65535), 0, blank},
			'{tri_frag(FUNC_TEST, 3, 7, 0, 0, 0, 200, 0, 0, 0, 200, 0), 0, blank},
			'{tri_frag(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, blank},
			'{tri_frag(FUNC_TEST, 0, 0, 0, 0, 100, 0, 64, 100, 64, 0, 100), 0, blank},
			'{tri_frag(FUNC_TEST, 512, 341, 8000, 5000, 30000, 8400, 5700, 100,
				8500, 5300, 65535), 0, blank}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (vectors[i])
			issue_fragment(vectors[i].frag, vectors[i].typed, vectors[i].want);
		for (int unsigned i = 0; i < RANDOM_FRAGS; i++) begin
			if (i == RANDOM_FRAGS / 3) begin
				src_idle_pct = 86;
				snk_stall_pct = 7;
			end else if (i == 2 * RANDOM_FRAGS / 3) begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			issue_fragment(random_frag(), 0, blank);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_shades.size() != 0)
			@(posedge clk);
		for (drain = 0; drain < 200; drain++)
			@(posedge clk);
		$display("%0d fragments and clears checked: %0d covered, %0d depth store updates,",
			vectors.size() + RANDOM_FRAGS, seen_covered, seen_pass);
		$display("under receiver stalls, sender gaps and full rate.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
